### rtl/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int POS_BITS  = 9;
  localparam int OP_BITS   = 3;
  localparam int ST_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_READ   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_LOCATE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_PRED   = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SUCC   = 3'd5;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd6;

  localparam logic [ST_BITS-1:0] STAT_OK       = 2'd0;
  localparam logic [ST_BITS-1:0] STAT_BAD_POS  = 2'd1;
  localparam logic [ST_BITS-1:0] STAT_FULL     = 2'd2;
  localparam logic [ST_BITS-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [ST_BITS-1:0]   status;
    logic [WORD_BITS-1:0] value;
    logic [POS_BITS-1:0]  position;
    logic [CNT_BITS-1:0]  length;
    logic                 empty;
  } res_t;

endpackage

### rtl/ple_ram.sv
module ple_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ple_ctrl.sv
module ple_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [ple_pkg::OP_BITS-1:0]        req_op,
  input  logic [ple_pkg::POS_BITS-1:0]       req_pos,
  input  logic [ple_pkg::WORD_BITS-1:0]      req_val,
  output logic                               res_valid,
  input  logic                               res_ready,
  output ple_pkg::res_t                      res,
  output logic                               mem_we,
  output logic [ple_pkg::IDX_BITS-1:0]       mem_waddr,
  output logic [ple_pkg::WORD_BITS-1:0]      mem_wdata,
  output logic [ple_pkg::IDX_BITS-1:0]       mem_raddr,
  input  logic [ple_pkg::WORD_BITS-1:0]      mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int IB = ple_pkg::IDX_BITS;
  localparam int CB = ple_pkg::CNT_BITS;
  localparam int PB = ple_pkg::POS_BITS;
  localparam int WB = ple_pkg::WORD_BITS;

  logic [1:0]                    state_r, state_nxt;
  logic [ple_pkg::OP_BITS-1:0]   op_r, op_nxt;
  logic [WB-1:0]                 val_r, val_nxt;
  logic [IB-1:0]                 ins_idx_r, ins_idx_nxt;
  logic [IB-1:0]                 c_r, c_nxt;
  logic [CB-1:0]                 rem_r, rem_nxt;
  logic                          pend_r, pend_nxt;
  logic [IB-1:0]                 pidx_r, pidx_nxt;
  logic                          first_r, first_nxt;
  logic                          hit_r, hit_nxt;
  logic [WB-1:0]                 prev_r, prev_nxt;
  logic [CB-1:0]                 count_r, count_nxt;
  logic [ple_pkg::ST_BITS-1:0]   status_r, status_nxt;
  logic [WB-1:0]                 oval_r, oval_nxt;
  logic [PB-1:0]                 opos_r, opos_nxt;

  logic            pos_ok_rd;
  logic            pos_ok_ins;
  logic [CB:0]     pos_w;
  logic [CB:0]     cnt_w;
  logic [CB-1:0]   rem_shift;

  assign pos_w      = (CB + 1)'(req_pos);
  assign cnt_w      = (CB + 1)'(count_r);
  assign pos_ok_rd  = (req_pos != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (req_pos != '0) && (pos_w <= cnt_w + (CB + 1)'(1));
  assign rem_shift  = CB'(cnt_w - pos_w + (CB + 1)'(1));

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status   = status_r;
    res.value    = oval_r;
    res.position = opos_r;
    res.length   = count_r;
    res.empty    = (count_r == '0);
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    ins_idx_nxt = ins_idx_r;
    c_nxt       = c_r;
    rem_nxt     = rem_r;
    pend_nxt    = pend_r;
    pidx_nxt    = pidx_r;
    first_nxt   = first_r;
    hit_nxt     = hit_r;
    prev_nxt    = prev_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    oval_nxt    = oval_r;
    opos_nxt    = opos_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata;
    mem_raddr   = c_r;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt      = req_op;
          val_nxt     = req_val;
          ins_idx_nxt = IB'(req_pos - PB'(1));
          status_nxt  = ple_pkg::STAT_OK;
          oval_nxt    = '0;
          opos_nxt    = '0;
          pend_nxt    = 1'b0;
          first_nxt   = 1'b1;
          hit_nxt     = 1'b0;
          state_nxt   = S_DONE;
          case (req_op)
            ple_pkg::OP_INSERT: begin
              if (!pos_ok_ins) begin
                status_nxt = ple_pkg::STAT_BAD_POS;
              end else if (cnt_w >= (CB + 1)'(ple_pkg::CAPACITY)) begin
                status_nxt = ple_pkg::STAT_FULL;
              end else begin
                c_nxt     = IB'(count_r - CB'(1));
                rem_nxt   = rem_shift;
                state_nxt = S_LOOP;
              end
            end
            ple_pkg::OP_DELETE: begin
              if (!pos_ok_rd) begin
                status_nxt = ple_pkg::STAT_BAD_POS;
              end else begin
                c_nxt     = IB'(req_pos - PB'(1));
                rem_nxt   = rem_shift;
                state_nxt = S_LOOP;
              end
            end
            ple_pkg::OP_READ: begin
              if (!pos_ok_rd) begin
                status_nxt = ple_pkg::STAT_BAD_POS;
              end else begin
                c_nxt     = IB'(req_pos - PB'(1));
                rem_nxt   = CB'(1);
                state_nxt = S_LOOP;
              end
            end
            ple_pkg::OP_LOCATE, ple_pkg::OP_PRED, ple_pkg::OP_SUCC: begin
              status_nxt = ple_pkg::STAT_NOTFOUND;
              c_nxt      = '0;
              rem_nxt    = count_r;
              state_nxt  = S_LOOP;
            end
            ple_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_LOOP: begin
        // Issue side: one read per cycle, walking down for insert, up otherwise.
        if (rem_r != '0) begin
          c_nxt    = (op_r == ple_pkg::OP_INSERT) ? c_r - IB'(1) : c_r + IB'(1);
          rem_nxt  = rem_r - CB'(1);
          pend_nxt = 1'b1;
          pidx_nxt = c_r;
        end else begin
          pend_nxt = 1'b0;
        end

        // Return side: the read data of the previous cycle is handled here.
        if (pend_r) begin
          first_nxt = 1'b0;
          case (op_r)
            ple_pkg::OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pidx_r + IB'(1);
            end
            ple_pkg::OP_DELETE: begin
              if (first_r) begin
                oval_nxt = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pidx_r - IB'(1);
              end
            end
            ple_pkg::OP_READ: begin
              oval_nxt  = mem_rdata;
              state_nxt = S_DONE;
            end
            ple_pkg::OP_LOCATE: begin
              if (mem_rdata == val_r) begin
                status_nxt = ple_pkg::STAT_OK;
                opos_nxt   = PB'(pidx_r) + PB'(1);
                state_nxt  = S_DONE;
              end
            end
            ple_pkg::OP_PRED: begin
              prev_nxt = mem_rdata;
              if ((pidx_r != '0) && (mem_rdata == val_r)) begin
                status_nxt = ple_pkg::STAT_OK;
                oval_nxt   = prev_r;
                state_nxt  = S_DONE;
              end
            end
            ple_pkg::OP_SUCC: begin
              if (hit_r) begin
                status_nxt = ple_pkg::STAT_OK;
                oval_nxt   = mem_rdata;
                state_nxt  = S_DONE;
              end else if ((mem_rdata == val_r) &&
                           ((CB + 1)'(pidx_r) + (CB + 1)'(1) < cnt_w)) begin
                hit_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (rem_r == '0) begin
          // Walk finished with nothing in flight.
          state_nxt = S_DONE;
          if (op_r == ple_pkg::OP_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = ins_idx_r;
            mem_wdata = val_r;
            count_nxt = count_r + CB'(1);
          end else if (op_r == ple_pkg::OP_DELETE) begin
            count_nxt = count_r - CB'(1);
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    ins_idx_r <= ins_idx_nxt;
    c_r       <= c_nxt;
    rem_r     <= rem_nxt;
    pidx_r    <= pidx_nxt;
    first_r   <= first_nxt;
    hit_r     <= hit_nxt;
    prev_r    <= prev_nxt;
    status_r  <= status_nxt;
    oval_r    <= oval_nxt;
    opos_r    <= opos_nxt;
  end

endmodule

### rtl/positional_list_engine_core.sv
// Positional list engine: an ordered list of up to 256 signed 32-bit words.
// Requests arrive on the in_ stream; the request kind (insert, delete, read,
// locate, predecessor, successor, clear) travels in in_tuser, the position and
// value in in_tdata. Every request gives exactly one result transaction on the
// out_ stream, with the status code in out_tuser and the value, position,
// list length and empty flag in out_tdata.
// The entries live in one synchronous RAM with a registered read port and a
// separate write port. Insert and delete move the tail of the list one entry
// per cycle, reading one entry while writing the one read the cycle before;
// the searches read one entry per cycle. The read and write addresses of a
// shift never coincide, so no forwarding is needed.
// Insert and delete walk the entries from the position to the end (an insert
// at the end walks none), a read fetches one entry, the searches walk from the
// head until a hit or the end, and clear or a rejected request needs no walk.
// The engine works on one request at a time; a new request is taken once the
// previous result has reached the output register.
// Reset empties the list at once (the length register is cleared; the RAM is
// not swept). When the receiver stalls, the result waits in the output
// register while the next request is accepted and processed.
module positional_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [8:0] position, [40:9] value, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] out_value, [40:32] out_position,
                                  // [49:41] list_length, [50] list_empty
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                                res_valid;
  logic                                res_ready;
  ple_pkg::res_t                       res;
  logic                                mem_we;
  logic [ple_pkg::IDX_BITS-1:0]        mem_waddr;
  logic [ple_pkg::WORD_BITS-1:0]       mem_wdata;
  logic [ple_pkg::IDX_BITS-1:0]        mem_raddr;
  logic [ple_pkg::WORD_BITS-1:0]       mem_rdata;

  logic                                out_valid_r, out_valid_nxt;
  ple_pkg::res_t                       out_res_r, out_res_nxt;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tuser),
    .req_pos   (in_tdata[8:0]),
    .req_val   (in_tdata[40:9]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ple_ram #(
    .DEPTH (ple_pkg::CAPACITY),
    .WIDTH (ple_pkg::WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'd0, out_res_r.empty, out_res_r.length,
                       out_res_r.position, out_res_r.value};

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ple_pkg::*;

  localparam logic [OP_BITS-1:0] OP_SPARE = 3'd7;

  // One queued request, carrying the result it should produce.
  typedef struct {
    logic [OP_BITS-1:0]   op;
    logic [POS_BITS-1:0]  pos;
    logic [WORD_BITS-1:0] val;
    bit                   drain_first;
    res_t                 outcome;
  } request_t;

  typedef enum logic [1:0] {FLOW_OPEN, FLOW_CHOPPY, FLOW_CHOKED} flow_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shadow copy of the list, updated as requests are queued.
  logic [WORD_BITS-1:0] list_words [0:CAPACITY-1];
  int                   list_len = 0;
  logic [WORD_BITS-1:0] value_pool [0:5];

  request_t request_q [$];
  res_t     result_due [$];
  request_t offered;
  res_t     want;
  int       total_requests = 0;
  int       n_sent = 0;
  int       n_seen = 0;
  int       faults = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  flow_t    flow = FLOW_OPEN;
  int       flow_left = 0;

  always #4 clk = ~clk;

  positional_list_engine_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Applies one request to the shadow list and returns the result the engine owes.
  function automatic res_t predict_list_result(input logic [OP_BITS-1:0] op,
                                               input logic [POS_BITS-1:0] pos_in,
                                               input logic [WORD_BITS-1:0] val);
    res_t r;
    int   p;
    int   k;
    r = '0;
    r.status = STAT_OK;
    p = pos_in;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = STAT_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (k = list_len; k > p - 1; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = STAT_BAD_POS;
        end else begin
          r.value = list_words[p-1];
          for (k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      OP_READ: begin
        if (p < 1 || p > list_len) r.status = STAT_BAD_POS;
        else r.value = list_words[p-1];
      end
      OP_LOCATE: begin
        r.status = STAT_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_words[k] == val) begin
            r.status   = STAT_OK;
            r.position = POS_BITS'(k + 1);
            break;
          end
        end
      end
      OP_PRED: begin
        // Matching starts at the second entry, so a hit on the first one is a miss.
        r.status = STAT_NOTFOUND;
        for (k = 1; k < list_len; k++) begin
          if (list_words[k] == val) begin
            r.status = STAT_OK;
            r.value  = list_words[k-1];
            break;
          end
        end
      end
      OP_SUCC: begin
        // The last entry has no successor, so matching stops one short of it.
        r.status = STAT_NOTFOUND;
        for (k = 0; k + 1 < list_len; k++) begin
          if (list_words[k] == val) begin
            r.status = STAT_OK;
            r.value  = list_words[k+1];
            break;
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.length = CNT_BITS'(list_len);
    r.empty  = (list_len == 0);
    return r;
  endfunction

  task automatic queue_request(input logic [OP_BITS-1:0] op, input int pos,
                               input logic [WORD_BITS-1:0] val, input bit drain_first);
    request_t rq;
    rq.op          = op;
    rq.pos         = POS_BITS'(pos);
    rq.val         = val;
    rq.drain_first = drain_first;
    rq.outcome     = predict_list_result(op, rq.pos, val);
    request_q.push_back(rq);
    total_requests++;
  endtask

  function automatic int pick_position(input int top);
    if ($urandom_range(0, 99) < 88) return (top == 0) ? 1 : $urandom_range(1, top);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return top + 1;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // Mostly values from a small pool so that searches hit, now and then any word.
  function automatic logic [WORD_BITS-1:0] pick_value();
    if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  task automatic queue_random_request(input bit drain_first);
    int ins_w;
    int r;
    ins_w = (list_len > 48) ? 15 : 35;
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      queue_request(OP_INSERT, pick_position(list_len + 1), pick_value(), drain_first);
    end else if (r < ins_w + 12) begin
      queue_request(OP_READ, pick_position(list_len), $urandom(), drain_first);
    end else if (r < ins_w + 22) begin
      queue_request(OP_LOCATE, $urandom_range(0, 511), pick_value(), drain_first);
    end else if (r < ins_w + 32) begin
      queue_request(OP_PRED, $urandom_range(0, 511), pick_value(), drain_first);
    end else if (r < ins_w + 42) begin
      queue_request(OP_SUCC, $urandom_range(0, 511), pick_value(), drain_first);
    end else if (r < ins_w + 44) begin
      queue_request(OP_CLEAR, $urandom_range(0, 511), $urandom(), drain_first);
    end else if (r < ins_w + 46) begin
      queue_request(OP_SPARE, $urandom_range(0, 511), $urandom(), drain_first);
    end else begin
      queue_request(OP_DELETE, pick_position(list_len), $urandom(), drain_first);
    end
  endtask

  task automatic check_field(input string label, input logic [WORD_BITS-1:0] exp_v,
                             input logic [WORD_BITS-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, got_v);
      faults++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps. A request marked
  // drain_first is held back until every earlier transaction has been answered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_due.push_back(offered.outcome);
        n_sent <= n_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (request_q[0].drain_first && (in_tvalid || n_sent != n_seen)) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, request_q[0].val, request_q[0].pos};
          in_tuser  <= request_q[0].op;
          offered   <= request_q[0];
          void'(request_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: switches between always ready, random ready and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      flow_left  <= 0;
    end else begin
      if (flow_left == 0) begin
        flow      <= flow_t'($urandom_range(0, 2));
        flow_left <= $urandom_range(20, 200);
      end else begin
        flow_left <= flow_left - 1;
      end
      case (flow)
        FLOW_OPEN:   out_tready <= 1'b1;
        FLOW_CHOPPY: out_tready <= 1'($urandom_range(0, 1));
        default:     out_tready <= ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  // Each accepted result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_seen <= n_seen + 1;
      if (result_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %h data %h",
                 $time, out_tuser, out_tdata);
        faults++;
      end else begin
        want = result_due.pop_front();
        check_field("status", WORD_BITS'(want.status), WORD_BITS'(out_tuser));
        check_field("value", want.value, out_tdata[31:0]);
        check_field("position", WORD_BITS'(want.position), WORD_BITS'(out_tdata[40:32]));
        check_field("length", WORD_BITS'(want.length), WORD_BITS'(out_tdata[49:41]));
        check_field("empty", WORD_BITS'(want.empty), WORD_BITS'(out_tdata[50]));
      end
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = $urandom();
    value_pool[5] = $urandom();

    // Directed: requests on an empty, a single-entry and a short list.
    queue_request(OP_READ, 1, 0, 0);
    queue_request(OP_DELETE, 1, 0, 0);
    queue_request(OP_LOCATE, 0, 32'h0, 0);
    queue_request(OP_PRED, 0, 32'h0, 0);
    queue_request(OP_SUCC, 0, 32'h0, 0);
    queue_request(OP_INSERT, 0, 32'h1234_5678, 0);
    queue_request(OP_INSERT, 2, 32'h1234_5678, 0);
    queue_request(OP_INSERT, 1, 32'h8000_0000, 0);
    queue_request(OP_PRED, 0, 32'h8000_0000, 0);
    queue_request(OP_SUCC, 0, 32'h8000_0000, 0);
    queue_request(OP_INSERT, 2, 32'h7FFF_FFFF, 0);
    queue_request(OP_INSERT, 1, 32'h0000_0000, 0);
    queue_request(OP_INSERT, 511, 32'hFFFF_FFFF, 0);
    queue_request(OP_READ, 3, 32'hFFFF_FFFF, 0);
    queue_request(OP_READ, 4, 0, 0);
    queue_request(OP_LOCATE, 0, 32'h7FFF_FFFF, 0);
    queue_request(OP_PRED, 0, 32'h0000_0000, 0);
    queue_request(OP_PRED, 511, 32'h8000_0000, 0);
    queue_request(OP_SUCC, 0, 32'h7FFF_FFFF, 0);
    queue_request(OP_SUCC, 0, 32'h0000_0000, 0);
    queue_request(OP_LOCATE, 0, 32'h0001_2345, 0);
    queue_request(OP_SPARE, 511, 32'hFFFF_FFFF, 0);
    queue_request(OP_DELETE, 2, 0, 0);
    queue_request(OP_DELETE, 0, 0, 0);
    queue_request(OP_CLEAR, 0, 0, 0);
    queue_request(OP_READ, 1, 0, 0);

    repeat (150) queue_random_request(0);

    // Fill to capacity, mostly appending, after letting the engine run dry.
    queue_request(OP_INSERT, list_len + 1, pick_value(), 1);
    while (list_len < CAPACITY) begin
      if ($urandom_range(0, 7) == 0)
        queue_request(OP_INSERT, $urandom_range(1, list_len + 1), pick_value(), 0);
      else
        queue_request(OP_INSERT, list_len + 1, pick_value(), 0);
    end
    // A full list: a bad position wins over the full check.
    queue_request(OP_INSERT, CAPACITY + 2, pick_value(), 0);
    queue_request(OP_INSERT, CAPACITY + 1, pick_value(), 0);
    queue_request(OP_INSERT, 1, pick_value(), 0);
    queue_request(OP_READ, CAPACITY, 0, 0);
    queue_request(OP_SUCC, 0, list_words[CAPACITY-1], 0);
    queue_request(OP_PRED, 0, list_words[CAPACITY-1], 0);
    repeat (30) queue_random_request(0);
    queue_request(OP_CLEAR, 0, 0, 0);

    queue_random_request(1);
    repeat (60) queue_random_request(0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_seen < total_requests) @(posedge clk);
    // Any result arriving during this tail has no expectation and is flagged.
    repeat (300) @(posedge clk);
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
